@@ rtl/ais_pkg.sv @@
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types and constants for the ascending array sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ais_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_WIDTH      = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      is_last;
   } req_type;

   typedef struct packed {
      value_type sorted_value;
      logic      end_of_run;
      logic      truncated;
   } rsp_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic      insert;
      logic      shift_out;
      value_type value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/ais_cell.sv @@
// ----------------------------------------------------------------------------
// ais_cell
// One slot of the insertion chain: holds one value, opens a gap for a smaller
// incoming value by taking its left neighbor, and shifts left on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ais_pkg::cell_ctrl_type ctrl,
   input  wire ais_pkg::value_type    left_val,
   input  wire logic                  left_valid,
   input  wire logic                  left_greater,
   input  wire ais_pkg::value_type    right_val,
   input  wire logic                  right_valid,
   output      ais_pkg::value_type    val,
   output      logic                  valid,
   output      logic                  greater
);

   ais_pkg::value_type val_ff, val_in;
   logic               valid_ff, valid_in;
   logic               take;

   assign greater = valid_ff && (val_ff > ctrl.value);
   assign take    = greater || (!valid_ff && left_valid);

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctrl.shift_out) begin
         val_in   = right_val;
         valid_in = right_valid;
      end else if (ctrl.insert && take) begin
         val_in   = left_greater ? left_val : ctrl.value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

@@ rtl/array_sorter_ascending.sv @@
// ----------------------------------------------------------------------------
// array_sorter_ascending
// Insertion-chain sorter: collects a run of signed values and emits them in
// ascending order, flagging runs that overflowed the chain.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while collecting; the chain sorts each
//   accepted item into place unless full. After the last item, busy holds
//   until all stored values are shifted out of cell 0, one result per
//   cycle from ST_DRAIN on. The receiver cannot stall the results.
// Reset: synchronous; clears all cell valid bits, the overflow flag and state.
// ----------------------------------------------------------------------------
`default_nettype none

module array_sorter_ascending #(
   parameter int CAPACITY = ais_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ais_pkg::req_type req_item,
   output      logic             busy,
   output      logic             rsp_strobe,
   output      ais_pkg::rsp_type rsp_item
);

   ais_pkg::state_type     state_ff, state_in;
   logic                   overflow_ff, overflow_in;
   ais_pkg::cell_ctrl_type ctrl;
   logic                   accept, full, run_done;

   ais_pkg::value_type cell_val     [CAPACITY];
   logic               cell_valid   [CAPACITY];
   logic               cell_greater [CAPACITY];

   assign accept   = start && !busy;
   assign full     = cell_valid[CAPACITY-1];
   assign run_done = !cell_valid[1];

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         ais_pkg::value_type lv, rv;
         logic               lvalid, lgreater, rvalid;
         if (gi == 0) begin : g_head
            assign lv       = '0;
            assign lvalid   = 1'b1;
            assign lgreater = 1'b0;
         end else begin : g_body
            assign lv       = cell_val[gi-1];
            assign lvalid   = cell_valid[gi-1];
            assign lgreater = cell_greater[gi-1];
         end
         if (gi == CAPACITY-1) begin : g_tail
            assign rv     = '0;
            assign rvalid = 1'b0;
         end else begin : g_inner
            assign rv     = cell_val[gi+1];
            assign rvalid = cell_valid[gi+1];
         end
         ais_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .left_val     (lv),
            .left_valid   (lvalid),
            .left_greater (lgreater),
            .right_val    (rv),
            .right_valid  (rvalid),
            .val          (cell_val[gi]),
            .valid        (cell_valid[gi]),
            .greater      (cell_greater[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ais_pkg::ST_COLLECT: begin
            if (accept && req_item.is_last) begin
               state_in = ais_pkg::ST_DRAIN;
            end
         end
         ais_pkg::ST_DRAIN: begin
            if (run_done) begin
               state_in = ais_pkg::ST_COLLECT;
            end
         end
         default: state_in = ais_pkg::ST_COLLECT;
      endcase
   end

   always_comb begin
      busy           = 1'b0;
      rsp_strobe     = 1'b0;
      ctrl.insert    = 1'b0;
      ctrl.shift_out = 1'b0;
      ctrl.value     = req_item.value;
      case (state_ff)
         ais_pkg::ST_COLLECT: begin
            ctrl.insert = accept && !full;
         end
         ais_pkg::ST_DRAIN: begin
            busy           = 1'b1;
            rsp_strobe     = 1'b1;
            ctrl.shift_out = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (state_ff == ais_pkg::ST_DRAIN && run_done) begin
         overflow_in = 1'b0;
      end else if (accept && full) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ais_pkg::ST_COLLECT;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_item.sorted_value = cell_val[0];
   assign rsp_item.end_of_run   = run_done;
   assign rsp_item.truncated    = overflow_ff;

endmodule

`default_nettype wire

@@ sim/array_sorter_ascending_test.sv @@
// ----------------------------------------------------------------------------
// array_sorter_ascending_test
// Drives runs of signed values into the sorter and checks that each run comes
// back in ascending order, with the end mark on the largest value and the
// truncation flag on every result of a run that overflowed the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module array_sorter_ascending_test;

   localparam int                 CAPACITY     = ais_pkg::CAPACITY_DEFAULT;
   localparam int                 RANDOM_ITEMS = 100;
   localparam ais_pkg::value_type VALUE_MAX    =
      {1'b0, {(ais_pkg::VALUE_WIDTH-1){1'b1}}};
   localparam ais_pkg::value_type VALUE_MIN    =
      {1'b1, {(ais_pkg::VALUE_WIDTH-1){1'b0}}};

   class ascending_run_tracker;
      ais_pkg::value_type run_store[$];
      logic               overflow_seen = 1'b0;
      ais_pkg::rsp_type   pending_sorted[$];
      int                 mismatch_count = 0;

      function void note_item(ais_pkg::req_type item);
         int               pos;
         ais_pkg::rsp_type expected;
         if (run_store.size() < CAPACITY) begin
            pos = run_store.size();
            while (pos > 0 && run_store[pos-1] > item.value) pos--;
            run_store.insert(pos, item.value);
         end else begin
            overflow_seen = 1'b1;
         end
         if (item.is_last) begin
            foreach (run_store[k]) begin
               expected.sorted_value = run_store[k];
               expected.end_of_run   = (k == run_store.size() - 1);
               expected.truncated    = overflow_seen;
               pending_sorted.push_back(expected);
            end
            run_store.delete();
            overflow_seen = 1'b0;
         end
      endfunction

      function void check_result(ais_pkg::rsp_type actual);
         ais_pkg::rsp_type expected;
         if (pending_sorted.size() == 0) begin
            $display("%0t: unexpected result: expected none, got value %0d end %0b trunc %0b",
                     $time, actual.sorted_value, actual.end_of_run, actual.truncated);
            mismatch_count++;
            return;
         end
         expected = pending_sorted.pop_front();
         if (actual.sorted_value !== expected.sorted_value) begin
            $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                     $time, expected.sorted_value, actual.sorted_value);
            mismatch_count++;
         end
         if (actual.end_of_run !== expected.end_of_run) begin
            $display("%0t: end_of_run mismatch: expected %0b, got %0b",
                     $time, expected.end_of_run, actual.end_of_run);
            mismatch_count++;
         end
         if (actual.truncated !== expected.truncated) begin
            $display("%0t: truncated mismatch: expected %0b, got %0b",
                     $time, expected.truncated, actual.truncated);
            mismatch_count++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   ais_pkg::req_type req_item;
   logic             busy;
   logic             rsp_strobe;
   ais_pkg::rsp_type rsp_item;

   ascending_run_tracker tracker;

   array_sorter_ascending #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_result(rsp_item);
         if (start && !busy) tracker.note_item(req_item);
      end
   end

   function automatic ais_pkg::value_type pick_value();
      int                 mode;
      ais_pkg::value_type v;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         v = $urandom;
      end else if (mode < 8) begin
         v = $signed($urandom_range(0, 15)) - 8;
      end else begin
         case ($urandom_range(0, 3))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = '0;
            default: v = '1;
         endcase
      end
      return v;
   endfunction

   task automatic send_item(input ais_pkg::value_type item_value, input logic item_last,
                            input bit no_gaps);
      int               gap;
      ais_pkg::req_type item;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      item.value   = item_value;
      item.is_last = item_last;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_run(input int run_len, input bit no_gaps);
      for (int i = 0; i < run_len; i++) send_item(pick_value(), i == run_len - 1, no_gaps);
   endtask

   // hold off new items until every expected result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending_sorted.size() != 0) @(posedge clock);
   endtask

   initial begin
      int random_sent;
      int run_index;
      int run_len;
      bit no_gaps;

      tracker  = new;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(VALUE_MIN, 1'b1, 1'b0);
      send_item(VALUE_MAX, 1'b0, 1'b1);
      send_item(VALUE_MIN, 1'b1, 1'b1);
      send_item(0, 1'b0, 1'b0);
      send_item(-1, 1'b0, 1'b0);
      send_item(1, 1'b0, 1'b0);
      send_item(0, 1'b0, 1'b0);
      send_item(-1, 1'b1, 1'b0);
      send_item(40, 1'b0, 1'b1);
      send_item(30, 1'b0, 1'b1);
      send_item(20, 1'b0, 1'b1);
      send_item(10, 1'b0, 1'b1);
      send_item(-10, 1'b1, 1'b1);
      send_item(32'h5555_5555, 1'b0, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b1, 1'b0);
      send_item(VALUE_MAX, 1'b0, 1'b0);
      send_item(VALUE_MAX, 1'b1, 1'b0);
      drain_results();

      random_sent = 0;
      run_index   = 0;
      while (random_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if (run_index == 3) run_len = CAPACITY + 3;
         else if ($urandom_range(0, 7) == 0) run_len = $urandom_range(9, 24);
         else run_len = $urandom_range(1, 8);
         send_run(run_len, no_gaps);
         random_sent += run_len;
         if (run_index == 5 || $urandom_range(0, 5) == 0) drain_results();
         run_index++;
      end

      drain_results();
      repeat (CAPACITY + 4) @(posedge clock);

      if (tracker.pending_sorted.size() != 0) begin
         $display("%0t: %0d expected results never arrived",
                  $time, tracker.pending_sorted.size());
         tracker.mismatch_count++;
      end
      if (tracker.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
